### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the decoder core RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define RLP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define RLP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define RLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rlp_pkg.sv
// ---------------------------------------------------------------------------
// rlp_pkg
// Types and constants of the RLP stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlp_pkg;

  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  // Header byte boundaries
  localparam logic [7:0] SINGLE_MAX     = 8'h7F;
  localparam logic [7:0] SHORT_STR_MAX  = 8'hB7;
  localparam logic [7:0] LONG_STR_MAX   = 8'hBF;
  localparam logic [7:0] SHORT_LIST_MAX = 8'hF7;
  localparam logic [7:0] STR_BASE       = 8'h80;
  localparam logic [7:0] LIST_BASE      = 8'hC0;
  localparam logic [7:0] LONG_STR_BIAS  = 8'hB7;
  localparam logic [7:0] LONG_LIST_BIAS = 8'hF7;

  typedef enum logic [3:0] {
    ROLE_SINGLE     = 4'd0,
    ROLE_SHORT_STR  = 4'd1,
    ROLE_LONG_STR   = 4'd2,
    ROLE_STR_LEN    = 4'd3,
    ROLE_PAYLOAD    = 4'd4,
    ROLE_SHORT_LIST = 4'd5,
    ROLE_LONG_LIST  = 4'd6,
    ROLE_LIST_LEN   = 4'd7,
    ROLE_IGNORED    = 4'd8
  } role_e;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_TRUNC_STR  = 3'd1,
    ERR_TRUNC_LEN  = 3'd2,
    ERR_TRUNC_LIST = 3'd3,
    ERR_EXTRA      = 3'd4,
    ERR_TOO_DEEP   = 3'd5,
    ERR_WIDE       = 3'd6,
    ERR_ENDED      = 3'd7
  } err_e;

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_LEN = 3'b010,
    PH_PAY = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    role_e      byte_role;
    logic [4:0] nest_depth;
    logic       string_done;
    logic [4:0] lists_closed;
    logic       message_done;
    err_e       error_code;
  } out_t;

  // Fixed-width parser control state
  typedef struct packed {
    logic [31:0] byte_position;
    phase_e      parse_phase;
    logic [3:0]  length_bytes_left;
    logic        pending_is_list;
    logic [31:0] string_end_position;
    logic        top_item_done;
    err_e        sticky_error;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    byte_position:       32'd0,
    parse_phase:         PH_HDR,
    length_bytes_left:   4'd0,
    pending_is_list:     1'b0,
    string_end_position: 32'd0,
    top_item_done:       1'b0,
    sticky_error:        ERR_OK
  };

endpackage

### sv/rlp_stream_decoder_core.sv
// ---------------------------------------------------------------------------
// rlp_stream_decoder_core - streaming RLP decoder, one byte per transfer
// A byte passes the input register, then the result register, to the output.
// Throughput: 1 byte per cycle unless the result side stalls; the stack top
//   lives in flops and the entry beneath its run is prefetched from the RAM.
// Reset: async, clears all control state; the stack RAM needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlp_stream_decoder_core #(
  parameter int unsigned MAX_DEPTH = 16,
  parameter int unsigned LEN_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rlp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rlp_pkg::out_t  out_data_o
);

  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned DUP_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned ENT_W = 32 + DUP_W;

  // Input stage: one byte waiting to be decoded
  logic          s1_valid_q, s1_valid_d;
  rlp_pkg::in_t  s1_data_q;

  // Result stage
  logic          out_valid_q, out_valid_d;
  rlp_pkg::out_t out_data_q;

  // Parser state; the stack top is cached next to the RAM copy
  rlp_pkg::ctl_t       ctl_q, ctl_d;
  logic [LVL_W-1:0]    level_q, level_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [31:0]         top_end_q, top_end_d;
  logic [DUP_W-1:0]    top_dup_q, top_dup_d;

  rlp_pkg::out_t       step_res;
  rlp_pkg::ctl_t       step_ctl;
  logic [LVL_W-1:0]    step_level;
  logic [LEN_BITS-1:0] step_acc;
  logic [31:0]         step_top_end;
  logic [DUP_W-1:0]    step_top_dup;
  logic                step_push;

  logic                adv;
  logic                in_xfer;
  logic                ram_we;
  logic [LVL_W-1:0]    rd_idx;
  logic [ENT_W-1:0]    ram_rdata;
  logic [31:0]         below_end;
  logic [DUP_W-1:0]    below_dup;

  // Advance the decoded byte into the result register whenever the result
  // slot is free or is being drained in this cycle. Every state update happens
  // on this edge, so the next byte always sees the state the previous one left.
  assign adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_xfer = in_valid_i && in_ready_o;

  // Accept a new byte while the input stage is empty or moves on now
  assign in_ready_o = !s1_valid_q || adv;

  assign s1_valid_d  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  rlp_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .LEN_BITS  (LEN_BITS)
  ) u_step (
    .in_i        (s1_data_q),
    .ctl_i       (ctl_q),
    .level_i     (level_q),
    .acc_i       (acc_q),
    .top_end_i   (top_end_q),
    .top_dup_i   (top_dup_q),
    .below_end_i (below_end),
    .below_dup_i (below_dup),
    .res_o       (step_res),
    .ctl_o       (step_ctl),
    .level_o     (step_level),
    .acc_o       (step_acc),
    .top_end_o   (step_top_end),
    .top_dup_o   (step_top_dup),
    .push_o      (step_push)
  );

  // Hold the state unless a byte is transferred into the result register
  assign ctl_d     = adv ? step_ctl     : ctl_q;
  assign level_d   = adv ? step_level   : level_q;
  assign acc_d     = adv ? step_acc     : acc_q;
  assign top_end_d = adv ? step_top_end : top_end_q;
  assign top_dup_d = adv ? step_top_dup : top_dup_q;

  // Stack RAM. A push writes the new top at the current level. The read port
  // always fetches the entry just beneath the run of equal ends at the top,
  // using the next state, so a pop of that run finds its new top ready. When
  // the stack holds only that run, the address is meaningless and the data
  // is never used.
  assign ram_we = adv && step_push;
  assign rd_idx = level_d - LVL_W'(top_dup_d) - LVL_W'(2);

  rlp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (level_q[AW-1:0]),
    .wdata_i ({top_end_d, top_dup_d}),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign below_end = ram_rdata[ENT_W-1:DUP_W];
  assign below_dup = ram_rdata[DUP_W-1:0];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q       <= rlp_pkg::CTL_RESET;
      level_q     <= '0;
      acc_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      ctl_q       <= ctl_d;
      level_q     <= level_d;
      acc_q       <= acc_d;
    end
  end

  // Payload: input byte, result, cached stack top
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (adv) begin
      out_data_q <= step_res;
    end
    top_end_q <= top_end_d;
    top_dup_q <= top_dup_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `RLP_ASSERT_ALWAYS(a_level_bound, level_q <= LVL_W'(MAX_DEPTH), "stack level above depth")
  `RLP_ASSERT_IMPL(a_push_room, ram_we, level_q < LVL_W'(MAX_DEPTH), "push into a full stack")
  `RLP_ASSERT_IMPL(a_dup_bound, level_q != '0, LVL_W'(top_dup_q) < level_q, "top run too long")
  `RLP_ASSERT_IMPL(a_done_clean, out_valid_q && out_data_q.message_done, out_data_q.error_code == rlp_pkg::ERR_OK, "message done with error")
  `RLP_ASSERT_NEXT(a_hold_state, s1_valid_q && out_valid_q && !out_ready_i, $stable(level_q) && $stable(ctl_q), "state moved while stalled")

endmodule

### sv/rlp_ram.sv
// ---------------------------------------------------------------------------
// rlp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlp_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rlp_step.sv
// ---------------------------------------------------------------------------
// rlp_step
// Next-state and result logic for one message byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlp_step #(
  parameter int unsigned MAX_DEPTH = 16,
  parameter int unsigned LEN_BITS  = 32,
  localparam int unsigned LVL_W    = $clog2(MAX_DEPTH + 1),
  localparam int unsigned DUP_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  rlp_pkg::in_t          in_i,
  input  rlp_pkg::ctl_t         ctl_i,
  input  logic [LVL_W-1:0]      level_i,
  input  logic [LEN_BITS-1:0]   acc_i,
  input  logic [31:0]           top_end_i,
  input  logic [DUP_W-1:0]      top_dup_i,
  input  logic [31:0]           below_end_i,
  input  logic [DUP_W-1:0]      below_dup_i,
  output rlp_pkg::out_t         res_o,
  output rlp_pkg::ctl_t         ctl_o,
  output logic [LVL_W-1:0]      level_o,
  output logic [LEN_BITS-1:0]   acc_o,
  output logic [31:0]           top_end_o,
  output logic [DUP_W-1:0]      top_dup_o,
  output logic                  push_o
);

  localparam int unsigned SUM_W = ((LEN_BITS > 32) ? LEN_BITS : 32) + 1;
  localparam int unsigned CW    = LVL_W + 1;

  logic [7:0]          b;
  logic [31:0]         start;
  logic                stk_nz;
  logic                end_ge_start;
  logic                is_single;
  logic                is_short_str;
  logic                is_short_list;
  logic                long_is_list;
  logic [3:0]          count;
  logic                err_count;
  logic                acc_over;
  logic [LEN_BITS-1:0] acc_shift;
  logic [3:0]          left_dec;
  logic                bi_list;
  logic [LEN_BITS-1:0] bi_len;
  logic [SUM_W-1:0]    bi_sum;
  logic                bi_wide;
  logic                bi_room;
  logic                bi_zero;
  logic                bi_deep;
  logic [31:0]         bi_end;
  logic [DUP_W-1:0]    bi_dup;

  rlp_pkg::role_e      role;
  rlp_pkg::err_e       err;
  logic [4:0]          depth;
  logic                sdone;
  logic                empty;
  logic                mdone;
  logic                use_begin;
  logic [LVL_W-1:0]    pops;
  logic [LVL_W-1:0]    level_after;
  logic [CW-1:0]       closed;

  assign b            = in_i.byte_value;
  assign start        = ctl_i.byte_position + 32'd1;
  assign stk_nz       = (level_i != '0);
  assign end_ge_start = (top_end_i >= start);

  // Header classes
  assign is_single     = (b <= rlp_pkg::SINGLE_MAX);
  assign is_short_str  = !is_single && (b <= rlp_pkg::SHORT_STR_MAX);
  assign is_short_list = (b >= rlp_pkg::LIST_BASE) && (b <= rlp_pkg::SHORT_LIST_MAX);
  assign long_is_list  = (b > rlp_pkg::LONG_STR_MAX);
  assign count         = long_is_list ? 4'(b - rlp_pkg::LONG_LIST_BIAS)
                                      : 4'(b - rlp_pkg::LONG_STR_BIAS);
  assign err_count     = stk_nz && end_ge_start &&
                         (({1'b0, start} + 33'(count)) > {1'b0, top_end_i});

  // Length byte accumulation, big-endian
  assign acc_over  = ((acc_i >> (LEN_BITS - 8)) != '0);
  assign acc_shift = (acc_i << 8) | LEN_BITS'(b);
  assign left_dec  = (ctl_i.length_bytes_left != 4'd0) ? ctl_i.length_bytes_left - 4'd1 : 4'd0;

  // Item start checks, shared by short headers and the last length byte
  assign bi_list = (ctl_i.parse_phase == rlp_pkg::PH_LEN) ? ctl_i.pending_is_list
                                                          : is_short_list;
  assign bi_len  = (ctl_i.parse_phase == rlp_pkg::PH_LEN) ? acc_shift :
                   is_short_list ? LEN_BITS'(b - rlp_pkg::LIST_BASE)
                                 : LEN_BITS'(b - rlp_pkg::STR_BASE);
  assign bi_sum  = SUM_W'(bi_len) + SUM_W'(start);
  assign bi_wide = (bi_sum > SUM_W'(rlp_pkg::POS_MAX));
  assign bi_room = stk_nz && end_ge_start && (bi_sum > SUM_W'(top_end_i));
  assign bi_zero = (bi_len == '0);
  assign bi_deep = (level_i >= LVL_W'(MAX_DEPTH));
  assign bi_end  = bi_sum[31:0];
  // Count entries below that end at the same place, so a pop needs one compare
  assign bi_dup  = (stk_nz && (top_end_i == bi_end)) ? top_dup_i + DUP_W'(1) : '0;

  assign level_after = level_i - pops;

  always_comb begin
    ctl_o     = ctl_i;
    level_o   = level_i;
    acc_o     = acc_i;
    top_end_o = top_end_i;
    top_dup_o = top_dup_i;
    push_o    = 1'b0;
    role      = rlp_pkg::ROLE_IGNORED;
    err       = rlp_pkg::ERR_OK;
    depth     = 5'd0;
    sdone     = 1'b0;
    empty     = 1'b0;
    mdone     = 1'b0;
    use_begin = 1'b0;
    pops      = '0;
    closed    = '0;

    if (ctl_i.sticky_error != rlp_pkg::ERR_OK) begin
      err = ctl_i.sticky_error;
    end else if (ctl_i.top_item_done) begin
      err = rlp_pkg::ERR_EXTRA;
    end else if (ctl_i.byte_position == rlp_pkg::POS_MAX) begin
      err = rlp_pkg::ERR_WIDE;
    end else begin
      depth = 5'(level_i);
      case (ctl_i.parse_phase)
        rlp_pkg::PH_LEN: begin
          role = ctl_i.pending_is_list ? rlp_pkg::ROLE_LIST_LEN : rlp_pkg::ROLE_STR_LEN;
          if (acc_over) begin
            err = rlp_pkg::ERR_WIDE;
          end else begin
            acc_o                   = acc_shift;
            ctl_o.length_bytes_left = left_dec;
            use_begin               = (left_dec == 4'd0);
          end
        end
        rlp_pkg::PH_PAY: begin
          role = rlp_pkg::ROLE_PAYLOAD;
          if (start == ctl_i.string_end_position) begin
            sdone             = 1'b1;
            ctl_o.parse_phase = rlp_pkg::PH_HDR;
          end
        end
        default: begin
          if (is_single) begin
            role  = rlp_pkg::ROLE_SINGLE;
            sdone = 1'b1;
          end else if (is_short_str) begin
            role      = rlp_pkg::ROLE_SHORT_STR;
            use_begin = 1'b1;
          end else if (is_short_list) begin
            role      = rlp_pkg::ROLE_SHORT_LIST;
            use_begin = 1'b1;
          end else begin
            role = long_is_list ? rlp_pkg::ROLE_LONG_LIST : rlp_pkg::ROLE_LONG_STR;
            if (err_count) begin
              err = rlp_pkg::ERR_TRUNC_LEN;
            end else begin
              ctl_o.pending_is_list   = long_is_list;
              ctl_o.length_bytes_left = count;
              ctl_o.parse_phase       = rlp_pkg::PH_LEN;
              acc_o                   = '0;
            end
          end
        end
      endcase

      if (use_begin) begin
        if (bi_wide) begin
          err = rlp_pkg::ERR_WIDE;
        end else if (bi_room) begin
          err = bi_list ? rlp_pkg::ERR_TRUNC_LIST : rlp_pkg::ERR_TRUNC_STR;
        end else begin
          ctl_o.parse_phase = rlp_pkg::PH_HDR;
          if (bi_zero) begin
            empty = bi_list;
            sdone = !bi_list;
          end else if (bi_list) begin
            if (bi_deep) begin
              err = rlp_pkg::ERR_TOO_DEEP;
            end else begin
              push_o    = 1'b1;
              top_end_o = bi_end;
              top_dup_o = bi_dup;
              level_o   = level_i + LVL_W'(1);
            end
          end else begin
            ctl_o.string_end_position = bi_end;
            ctl_o.parse_phase         = rlp_pkg::PH_PAY;
          end
        end
      end

      if (err == rlp_pkg::ERR_OK) begin
        if (sdone || empty) begin
          // Drop the whole run of lists that end right here
          if (stk_nz && (top_end_i == start)) begin
            pops      = LVL_W'(top_dup_i) + LVL_W'(1);
            top_end_o = below_end_i;
            top_dup_o = below_dup_i;
          end
          level_o = level_after;
          if (level_after == '0) begin
            ctl_o.top_item_done = 1'b1;
            mdone               = 1'b1;
          end
        end
        closed = CW'(empty) + CW'(pops);
      end else begin
        ctl_o.sticky_error = err;
        sdone              = 1'b0;
      end
      ctl_o.byte_position = ctl_i.byte_position + 32'd1;
    end

    if (in_i.last_byte) begin
      if ((err == rlp_pkg::ERR_OK) && !ctl_o.top_item_done) begin
        err = rlp_pkg::ERR_ENDED;
      end
      ctl_o   = rlp_pkg::CTL_RESET;
      level_o = '0;
      acc_o   = '0;
    end
  end

  always_comb begin
    res_o              = '0;
    res_o.echo_byte    = b;
    res_o.byte_role    = role;
    res_o.nest_depth   = depth;
    res_o.string_done  = sdone;
    res_o.lists_closed = 5'(closed);
    res_o.message_done = mdone;
    res_o.error_code   = err;
  end

endmodule

### tb/rlp_stream_decoder_core_tb.sv
// ---------------------------------------------------------------------------
// rlp_stream_decoder_core_tb
// Self-checking bench for the streaming RLP decoder: a byte-level tag
// predictor runs beside the block, and every result transfer is compared
// field by field against the oldest predicted tag set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import rlp_pkg::*;

typedef logic [7:0] bytes_t [$];

// Predict the tags of each accepted byte and check the block's results.
class rlp_tag_scoreboard;
  localparam int unsigned MAX_LEVELS = 16;
  localparam int unsigned LEN_W      = 32;

  // Parser state mirrored at byte granularity
  logic [31:0] list_end [MAX_LEVELS];
  int unsigned level;
  logic [31:0] pos;
  phase_e      phase;
  logic [3:0]  len_left;
  logic [63:0] len_acc;
  bit          pend_list;
  logic [31:0] str_end;
  bit          top_done;
  err_e        sticky;

  out_t        expected_tags [$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned bytes_noted;
  int unsigned active_bytes;
  int unsigned code_hits [8];

  function new();
    clear_state();
  endfunction

  function void clear_state();
    foreach (list_end[i]) list_end[i] = '0;
    level     = 0;
    pos       = '0;
    phase     = PH_HDR;
    len_left  = '0;
    len_acc   = '0;
    pend_list = 1'b0;
    str_end   = '0;
    top_done  = 1'b0;
    sticky    = ERR_OK;
  endfunction

  // Room left in the innermost open list, unbounded at top level.
  function logic [63:0] room_from(logic [63:0] start);
    if (level == 0) return '1;
    return {32'b0, list_end[level-1]} - start;
  endfunction

  function err_e begin_item(bit is_list, logic [63:0] len, logic [63:0] start,
                            output bit sdone, output bit empty);
    sdone = 1'b0;
    empty = 1'b0;
    if (len > 64'hFFFF_FFFF - start) return ERR_WIDE;
    if (len > room_from(start)) return is_list ? ERR_TRUNC_LIST : ERR_TRUNC_STR;
    phase = PH_HDR;
    if (len == 0) begin
      if (is_list) empty = 1'b1;
      else sdone = 1'b1;
      return ERR_OK;
    end
    if (is_list) begin
      if (level >= MAX_LEVELS) return ERR_TOO_DEEP;
      list_end[level] = 32'(start + len);
      level++;
    end else begin
      str_end = 32'(start + len);
      phase   = PH_PAY;
    end
    return ERR_OK;
  endfunction

  // Advance the mirrored parser by one byte and queue the tags it earns.
  function void note_byte(in_t item);
    logic [7:0]  b;
    logic [7:0]  hdr_len;
    logic [63:0] start;
    role_e       role;
    err_e        err;
    int unsigned depth, closed;
    bit          sdone, empty, mdone, is_list;
    out_t        tags;
    b      = item.byte_value;
    role   = ROLE_IGNORED;
    err    = ERR_OK;
    depth  = 0;
    closed = 0;
    sdone  = 1'b0;
    empty  = 1'b0;
    mdone  = 1'b0;
    if (sticky != ERR_OK) begin
      err = sticky;
    end else if (top_done) begin
      err = ERR_EXTRA;
    end else if (pos == POS_MAX) begin
      err = ERR_WIDE;
    end else begin
      start = {32'b0, pos} + 64'd1;
      depth = level;
      case (phase)
        PH_LEN: begin
          role = pend_list ? ROLE_LIST_LEN : ROLE_STR_LEN;
          if ((len_acc >> (LEN_W - 8)) != 0) begin
            err = ERR_WIDE;
          end else begin
            len_acc = (len_acc << 8) | {56'b0, b};
            if (len_left > 0) len_left--;
            if (len_left == 0) err = begin_item(pend_list, len_acc, start, sdone, empty);
          end
        end
        PH_PAY: begin
          role = ROLE_PAYLOAD;
          if (start == {32'b0, str_end}) begin
            sdone = 1'b1;
            phase = PH_HDR;
          end
        end
        default: begin
          if (b <= SINGLE_MAX) begin
            role  = ROLE_SINGLE;
            sdone = 1'b1;
          end else if (b <= SHORT_STR_MAX) begin
            role    = ROLE_SHORT_STR;
            hdr_len = b - STR_BASE;
            err     = begin_item(1'b0, {56'b0, hdr_len}, start, sdone, empty);
          end else if (b >= LIST_BASE && b <= SHORT_LIST_MAX) begin
            role    = ROLE_SHORT_LIST;
            hdr_len = b - LIST_BASE;
            err     = begin_item(1'b1, {56'b0, hdr_len}, start, sdone, empty);
          end else begin
            // Long form: hdr_len is the count of length bytes that follow
            is_list = (b > LONG_STR_MAX);
            hdr_len = is_list ? b - LONG_LIST_BIAS : b - LONG_STR_BIAS;
            role    = is_list ? ROLE_LONG_LIST : ROLE_LONG_STR;
            if ({56'b0, hdr_len} > room_from(start)) begin
              err = ERR_TRUNC_LEN;
            end else begin
              pend_list = is_list;
              len_left  = hdr_len[3:0];
              len_acc   = '0;
              phase     = PH_LEN;
            end
          end
        end
      endcase

      if (err == ERR_OK) begin
        closed = empty;
        if (sdone || empty) begin
          while (level > 0 && {32'b0, list_end[level-1]} == start) begin
            level--;
            closed++;
          end
          if (level == 0) begin
            top_done = 1'b1;
            mdone    = 1'b1;
          end
        end
      end else begin
        sticky = err;
        sdone  = 1'b0;
        closed = 0;
      end
      pos++;
    end

    if (item.last_byte) begin
      if (err == ERR_OK && !top_done) err = ERR_ENDED;
      clear_state();
    end

    tags.echo_byte    = b;
    tags.byte_role    = role;
    tags.nest_depth   = 5'(depth);
    tags.string_done  = sdone;
    tags.lists_closed = 5'(closed);
    tags.message_done = mdone;
    tags.error_code   = err;
    expected_tags.insert(expected_tags.size(), tags);
    bytes_noted++;
    if (role != ROLE_IGNORED) active_bytes++;
  endfunction

  task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("[%0t] mismatch at result %0d: %s expected 0x%0h got 0x%0h",
             $realtime, results_checked, what, want, got);
  endtask

  task check_tags(out_t got);
    out_t want;
    if (expected_tags.size() == 0) begin
      report_mismatch("result with nothing pending, echo_byte", '0, got.echo_byte);
      return;
    end
    want = expected_tags.pop_front();
    results_checked++;
    code_hits[want.error_code]++;
    if (got.echo_byte !== want.echo_byte)
      report_mismatch("echo_byte", want.echo_byte, got.echo_byte);
    if (got.byte_role !== want.byte_role)
      report_mismatch("byte_role", want.byte_role, got.byte_role);
    if (got.nest_depth !== want.nest_depth)
      report_mismatch("nest_depth", want.nest_depth, got.nest_depth);
    if (got.string_done !== want.string_done)
      report_mismatch("string_done", want.string_done, got.string_done);
    if (got.lists_closed !== want.lists_closed)
      report_mismatch("lists_closed", want.lists_closed, got.lists_closed);
    if (got.message_done !== want.message_done)
      report_mismatch("message_done", want.message_done, got.message_done);
    if (got.error_code !== want.error_code)
      report_mismatch("error_code", want.error_code, got.error_code);
  endtask
endclass

module rlp_stream_decoder_core_tb;

  localparam int unsigned RANDOM_ITEMS   = 1650;
  localparam int unsigned HOLD_CYCLES    = 240;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  in_t   in_data_i   = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  out_t  out_data_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off       = 1'b0;
  int unsigned quiet_cycles   = 0;
  event        hold_ev;

  rlp_tag_scoreboard sb;

  rlp_stream_decoder_core #(
    .MAX_DEPTH (16),
    .LEN_BITS  (32)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Randomize the result-side ready each cycle; drop it entirely while a
  // hold-off is running so the pipeline backs up into the input.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Count the hold-off in its own process; the sender keeps offering bytes.
  initial begin
    forever begin
      @(hold_ev);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  // Observe both channels. Note the input transfer before checking the
  // result so a block with same-cycle results would still line up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_tags(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still pending",
                 quiet_cycles, sb.expected_tags.size());
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic bytes_t cat(bytes_t a, bytes_t b);
    return {a, b};
  endfunction

  // Build a long-form header: bias plus count, then big-endian length bytes,
  // sometimes with a leading zero the decoder must accept.
  function automatic bytes_t len_header(logic [7:0] bias, int unsigned n);
    bytes_t      lb;
    bytes_t      hdr;
    int unsigned v;
    v = n;
    do begin
      lb.push_front(8'(v & 255));
      v = v >> 8;
    end while (v != 0);
    if ($urandom_range(0, 3) == 0) lb.push_front(8'h00);
    hdr.insert(hdr.size(), bias + 8'(lb.size()));
    return cat(hdr, lb);
  endfunction

  function automatic bytes_t make_leaf();
    bytes_t      item;
    int unsigned kind, n;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      item.insert(item.size(), 8'($urandom_range(0, 127)));
    end else if (kind < 70) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 55) : $urandom_range(0, 6);
      item.insert(item.size(), STR_BASE + 8'(n));
      repeat (n) item.insert(item.size(), 8'($urandom));
    end else if (kind < 80) begin
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 8);
      item = len_header(LONG_STR_BIAS, n);
      repeat (n) item.insert(item.size(), 8'($urandom));
    end else if (kind < 92) begin
      item.insert(item.size(), LIST_BASE);
    end else begin
      item = len_header(LONG_LIST_BIAS, 0);
    end
    return item;
  endfunction

  // Well-formed message: a leaf, or a chain of lists with string and
  // empty-list siblings around each level.
  function automatic bytes_t make_message();
    bytes_t      body;
    bytes_t      hdr;
    int unsigned levels;
    levels = ($urandom_range(0, 4) == 0) ? 0 :
             $urandom_range(1, ($urandom_range(0, 5) == 0) ? 8 : 3);
    if (levels == 0) return make_leaf();
    repeat ($urandom_range(0, 3)) body = cat(body, make_leaf());
    for (int i = 0; i < levels; i++) begin
      if (body.size() <= 55 && $urandom_range(0, 3) != 0) begin
        hdr.delete();
        hdr.insert(hdr.size(), LIST_BASE + 8'(body.size()));
      end else begin
        hdr = len_header(LONG_LIST_BIAS, body.size());
      end
      body = cat(hdr, body);
      if (i < levels - 1) begin
        repeat ($urandom_range(0, 2)) body = cat(make_leaf(), body);
        repeat ($urandom_range(0, 2)) body = cat(body, make_leaf());
      end
    end
    return body;
  endfunction

  // Offer one message, flagging its final byte; idle between bytes at the
  // current sender rate. Returns at the edge where the last byte transfers.
  task automatic send_message(input bytes_t m);
    in_t item;
    for (int i = 0; i < m.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      item.byte_value = m[i];
      item.last_byte  = (i == m.size() - 1);
      in_valid_i <= 1'b1;
      in_data_i  <= item;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
  endtask

  initial begin
    bytes_t      msg;
    int unsigned msg_idx, pick, cut;
    string       codes;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages, no idling: byte extremes, empty items, a triple
    // close, long forms, each inner overrun, extra input, an early end and
    // an item end beyond the position range.
    msg = {8'h7F};                      send_message(msg);
    msg = {8'h80};                      send_message(msg);
    msg = {8'hC0};                      send_message(msg);
    msg = {8'hC3, 8'hC2, 8'hC1, 8'h00}; send_message(msg);
    msg = {8'hB8, 8'h01, 8'hFF};        send_message(msg);
    msg = {8'hF8, 8'h01, 8'h80};        send_message(msg);
    msg = {8'hC1, 8'h82};               send_message(msg);
    msg = {8'hC1, 8'hB9};               send_message(msg);
    msg = {8'hC1, 8'hC2};               send_message(msg);
    msg = {8'h05, 8'h06};               send_message(msg);
    msg = {8'h83, 8'h01};               send_message(msg);
    msg = {8'hBB, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message(msg);

    msg_idx = 0;
    while (sb.bytes_noted < RANDOM_ITEMS) begin
      // Rotate idling every eight messages
      case ((msg_idx / 8) % 4)
        0:       begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct <= 65; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct <= 0;  recv_stall_pct <= 65; end
        default: begin send_idle_pct <= 14; recv_stall_pct <= 14; end
      endcase
      if (msg_idx == 4 || msg_idx == 70) -> hold_ev;

      pick = $urandom_range(0, 99);
      msg  = make_message();
      if (pick >= 60 && pick < 68) begin
        // Nested chain of 13 to 17 lists; the stack limit is hit at seventeen
        msg.delete();
        msg.insert(msg.size(), 8'($urandom_range(0, 127)));
        repeat ($urandom_range(13, 17)) msg.push_front(LIST_BASE + 8'(msg.size()));
      end else if (pick < 76 && pick >= 68) begin
        // Cut the message short
        if (msg.size() > 1) begin
          cut = $urandom_range(1, msg.size() - 1);
          while (msg.size() > cut) void'(msg.pop_back());
        end
      end else if (pick < 84 && pick >= 76) begin
        repeat ($urandom_range(1, 3)) msg.insert(msg.size(), 8'($urandom));
      end else if (pick < 90 && pick >= 84) begin
        msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
      end else if (pick < 96 && pick >= 90) begin
        // Long-form header with random, often oversized, length bytes
        msg.delete();
        msg.insert(msg.size(), ($urandom_range(0, 1) ? LONG_STR_BIAS : LONG_LIST_BIAS) +
                               8'($urandom_range(1, 8)));
        repeat ($urandom_range(1, 9))
          msg.insert(msg.size(), $urandom_range(0, 1) ? 8'hFF : 8'($urandom));
        repeat ($urandom_range(0, 3)) msg.insert(msg.size(), 8'($urandom));
      end else if (pick >= 96) begin
        msg.delete();
        repeat ($urandom_range(1, 12)) msg.insert(msg.size(), 8'($urandom));
      end
      send_message(msg);
      msg_idx++;
    end

    // Drain: stop offering, wait for every predicted result, then linger
    in_valid_i <= 1'b0;
    while (sb.expected_tags.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    codes = "";
    for (int c = 0; c < 8; c++) codes = {codes, $sformatf(" %0d:%0d", c, sb.code_hits[c])};
    $display("Coverage: %0d random messages after the directed set, %0d bytes, %0d decoded",
             msg_idx, sb.bytes_noted, sb.active_bytes);
    $display("Coverage: results checked %0d, error code counts%s", sb.results_checked, codes);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
